// ----- hdl/acfc_pkg.sv -----
// Shared types, constants and a helper function of the audio capture FIFO card.
package acfc_pkg;

  localparam int FIFO_DEPTH = 4096;
  localparam int REG_COUNT  = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int OFF_W      = $clog2(REG_COUNT);
  localparam int RATE_W     = 19;
  localparam int CHAN_W     = 3;

  localparam logic [31:0]       RATE_MIN   = 32'd8000;
  localparam logic [31:0]       RATE_MAX   = 32'd384000;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);
  localparam logic [31:0]       BASE_RESET = 32'h1000_0000;
  localparam logic [7:0]        CHAN_MAX   = 8'd7;
  localparam logic [3:0]        FRAME_CHANS_MAX = 4'd8;
  localparam logic [7:0]        EMPTY_BYTE = 8'h80;

  // Commands.
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_PEEK  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_FRAME = 3'd3;
  localparam logic [2:0] CMD_RESET = 3'd4;

  // Register offsets inside the window.
  localparam logic [OFF_W-1:0] OFF_DATA   = OFF_W'(0);
  localparam logic [OFF_W-1:0] OFF_CTRL   = OFF_W'(1);
  localparam logic [OFF_W-1:0] OFF_STATUS = OFF_W'(2);
  localparam logic [OFF_W-1:0] OFF_RATE0  = OFF_W'(3);
  localparam logic [OFF_W-1:0] OFF_RATE1  = OFF_W'(4);
  localparam logic [OFF_W-1:0] OFF_RATE2  = OFF_W'(5);
  localparam logic [OFF_W-1:0] OFF_RATE3  = OFF_W'(6);
  localparam logic [OFF_W-1:0] OFF_FILL0  = OFF_W'(7);
  localparam logic [OFF_W-1:0] OFF_FILL1  = OFF_W'(8);
  localparam logic [OFF_W-1:0] OFF_CHAN   = OFF_W'(9);
  localparam logic [OFF_W-1:0] OFF_TIME0  = OFF_W'(10);
  localparam logic [OFF_W-1:0] OFF_TIME1  = OFF_W'(11);
  localparam logic [OFF_W-1:0] OFF_TIME2  = OFF_W'(12);
  localparam logic [OFF_W-1:0] OFF_TIME3  = OFF_W'(13);

  // Control register bits.
  localparam int CTRL_RUN   = 0;
  localparam int CTRL_CLEAR = 1;
  localparam int CTRL_START = 2;

  // Status and flag-clear bits.
  localparam int STAT_ON       = 0;
  localparam int STAT_NONEMPTY = 1;
  localparam int STAT_FULL     = 2;
  localparam int STAT_MISSING  = 5;
  localparam int STAT_UNDER    = 6;
  localparam int STAT_OVER     = 7;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        address;
    logic [7:0]         write_data;
    logic [31:0]        now_ms;
    logic signed [15:0] frame_sample;
    logic [3:0]         frame_channels;
    logic               frame_rate_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              error;
    logic [RATE_W-1:0] capture_rate;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- hdl/acfc_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module acfc_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/acfc_ctrl.sv -----
// Card state registers and the per-item register window, capture and FIFO logic.
module acfc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               proc_i,
  input  acfc_pkg::in_item_t item_i,
  input  logic [31:0]        base_i,
  input  logic [7:0]         mem_rdata_i,
  output acfc_pkg::mem_req_t mem_req_o,
  output acfc_pkg::out_item_t res_o
);

  logic [acfc_pkg::PTR_W-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [acfc_pkg::CNT_W-1:0]  fc_q, fc_d;
  logic                        cap_q, cap_d;
  logic                        uf_q, uf_d, of_q, of_d, mf_q, mf_d;
  logic [acfc_pkg::RATE_W-1:0] ar_q, ar_d;
  logic [31:0]                 rr_q, rr_d;
  logic [acfc_pkg::CHAN_W-1:0] ch_q, ch_d;
  logic                        byp_q, byp_d;
  logic [7:0]                  byp_data_q;

  logic [7:0] fifo_head;
  logic       push;
  logic [7:0] push_data;

  // The RAM reads at the head pointer's next value, so its registered output
  // is the head byte in the following cycle. A push to that same address is forwarded.
  assign fifo_head = byp_q ? byp_data_q : mem_rdata_i;
  assign push_data = {~item_i.frame_sample[15], item_i.frame_sample[14:8]};

  always_comb begin
    logic [32:0]                diff;
    logic                       in_win;
    logic [acfc_pkg::OFF_W-1:0] off;
    logic                       rr_ok;
    logic                       fail;
    logic [1:0]                 bsel;
    logic [31:0]                fc32;
    logic [7:0]                 stat;
    logic [7:0]                 rdata;
    logic                       err;
    logic                       push_c;

    rp_d = rp_q; wp_d = wp_q; fc_d = fc_q; cap_d = cap_q;
    uf_d = uf_q; of_d = of_q; mf_d = mf_q;
    ar_d = ar_q; rr_d = rr_q; ch_d = ch_q;
    rdata  = '0;
    err    = 1'b0;
    push_c = 1'b0;
    fail   = 1'b0;

    diff   = {1'b0, item_i.address} - {1'b0, base_i};
    in_win = !diff[32] && (diff[31:acfc_pkg::OFF_W] == '0);
    off    = diff[acfc_pkg::OFF_W-1:0];
    rr_ok  = (rr_q >= acfc_pkg::RATE_MIN) && (rr_q <= acfc_pkg::RATE_MAX);
    bsel   = '0;
    fc32   = 32'(fc_q);

    stat = '0;
    stat[acfc_pkg::STAT_ON]       = cap_q;
    stat[acfc_pkg::STAT_NONEMPTY] = (fc_q != '0);
    stat[acfc_pkg::STAT_FULL]     = (fc_q == acfc_pkg::CNT_W'(acfc_pkg::FIFO_DEPTH));
    stat[acfc_pkg::STAT_MISSING]  = mf_q;
    stat[acfc_pkg::STAT_UNDER]    = uf_q;
    stat[acfc_pkg::STAT_OVER]     = of_q;

    case (item_i.command)
      acfc_pkg::CMD_READ, acfc_pkg::CMD_PEEK: begin
        if (!in_win) begin
          err = 1'b1;
        end else begin
          case (off)
            acfc_pkg::OFF_DATA: begin
              if (fc_q == '0) begin
                rdata = acfc_pkg::EMPTY_BYTE;
                if (item_i.command == acfc_pkg::CMD_READ) uf_d = 1'b1;
              end else begin
                rdata = fifo_head;
                if (item_i.command == acfc_pkg::CMD_READ) begin
                  rp_d = acfc_pkg::next_ptr(rp_q);
                  fc_d = fc_q - 1'b1;
                end
              end
            end
            acfc_pkg::OFF_CTRL:   rdata = {7'd0, cap_q};
            acfc_pkg::OFF_STATUS: rdata = stat;
            acfc_pkg::OFF_RATE0, acfc_pkg::OFF_RATE1,
            acfc_pkg::OFF_RATE2, acfc_pkg::OFF_RATE3: begin
              bsel  = 2'(off - acfc_pkg::OFF_RATE0);
              rdata = rr_q[{bsel, 3'b000} +: 8];
            end
            acfc_pkg::OFF_FILL0: rdata = fc32[7:0];
            acfc_pkg::OFF_FILL1: rdata = fc32[15:8];
            acfc_pkg::OFF_CHAN:  rdata = 8'(ch_q);
            acfc_pkg::OFF_TIME0, acfc_pkg::OFF_TIME1,
            acfc_pkg::OFF_TIME2, acfc_pkg::OFF_TIME3: begin
              bsel  = 2'(off - acfc_pkg::OFF_TIME0);
              rdata = item_i.now_ms[{bsel, 3'b000} +: 8];
            end
            default: rdata = '0;
          endcase
        end
      end

      acfc_pkg::CMD_WRITE: begin
        if (!in_win) begin
          err = 1'b1;
        end else begin
          case (off)
            acfc_pkg::OFF_CTRL: begin
              if (item_i.write_data[acfc_pkg::CTRL_CLEAR]) begin
                rp_d = '0; wp_d = '0; fc_d = '0;
              end
              if (item_i.write_data[acfc_pkg::CTRL_START]) begin
                if (!rr_ok) begin
                  fail = 1'b1;
                end else begin
                  if (32'(ar_d) != rr_q) begin
                    rp_d = '0; wp_d = '0; fc_d = '0;
                  end
                  ar_d  = rr_q[acfc_pkg::RATE_W-1:0];
                  cap_d = 1'b1;
                  mf_d  = 1'b0;
                end
              end
              if (!fail) begin
                if (item_i.write_data[acfc_pkg::CTRL_RUN]) begin
                  if (!cap_d) begin
                    if (!rr_ok) begin
                      fail = 1'b1;
                    end else begin
                      if (32'(ar_d) != rr_q) begin
                        rp_d = '0; wp_d = '0; fc_d = '0;
                      end
                      ar_d  = rr_q[acfc_pkg::RATE_W-1:0];
                      cap_d = 1'b1;
                      mf_d  = 1'b0;
                    end
                  end
                end else if (cap_d) begin
                  cap_d = 1'b0;
                  rp_d = '0; wp_d = '0; fc_d = '0;
                end
              end
              err = fail;
            end
            acfc_pkg::OFF_STATUS: begin
              if (item_i.write_data[acfc_pkg::STAT_MISSING]) mf_d = 1'b0;
              if (item_i.write_data[acfc_pkg::STAT_UNDER])   uf_d = 1'b0;
              if (item_i.write_data[acfc_pkg::STAT_OVER])    of_d = 1'b0;
            end
            acfc_pkg::OFF_RATE0, acfc_pkg::OFF_RATE1,
            acfc_pkg::OFF_RATE2, acfc_pkg::OFF_RATE3: begin
              bsel = 2'(off - acfc_pkg::OFF_RATE0);
              rr_d[{bsel, 3'b000} +: 8] = item_i.write_data;
            end
            acfc_pkg::OFF_CHAN: begin
              if (item_i.write_data > acfc_pkg::CHAN_MAX) begin
                err = 1'b1;
              end else begin
                ch_d = item_i.write_data[acfc_pkg::CHAN_W-1:0];
                rp_d = '0; wp_d = '0; fc_d = '0;
              end
            end
            default: ;
          endcase
        end
      end

      acfc_pkg::CMD_FRAME: begin
        if (cap_q) begin
          if (!item_i.frame_rate_ok || (item_i.frame_channels == '0) ||
              (item_i.frame_channels > acfc_pkg::FRAME_CHANS_MAX) ||
              (4'(ch_q) >= item_i.frame_channels)) begin
            mf_d = (4'(ch_q) >= item_i.frame_channels);
          end else begin
            mf_d = 1'b0;
            if (fc_q == acfc_pkg::CNT_W'(acfc_pkg::FIFO_DEPTH)) begin
              of_d = 1'b1;
            end else begin
              push_c = 1'b1;
              wp_d   = acfc_pkg::next_ptr(wp_q);
              fc_d   = fc_q + 1'b1;
            end
          end
        end
      end

      acfc_pkg::CMD_RESET: begin
        cap_d = 1'b0;
        rp_d = '0; wp_d = '0; fc_d = '0;
        uf_d = 1'b0; of_d = 1'b0; mf_d = 1'b0;
        rr_d = 32'(ar_q);
      end

      default: ;
    endcase

    push = push_c;
    res_o.read_data    = rdata;
    res_o.error        = err;
    res_o.capture_rate = cap_d ? ar_d : '0;
  end

  always_comb begin
    mem_req_o.we    = proc_i && push;
    mem_req_o.waddr = wp_q;
    mem_req_o.wdata = push_data;
    mem_req_o.raddr = proc_i ? rp_d : rp_q;
    byp_d           = mem_req_o.we && (wp_q == mem_req_o.raddr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      fc_q  <= '0;
      cap_q <= 1'b0;
      uf_q  <= 1'b0;
      of_q  <= 1'b0;
      mf_q  <= 1'b0;
      ar_q  <= acfc_pkg::RATE_RESET;
      rr_q  <= 32'(acfc_pkg::RATE_RESET);
      ch_q  <= '0;
      byp_q <= 1'b0;
    end else begin
      byp_q <= byp_d;
      if (proc_i) begin
        rp_q  <= rp_d;
        wp_q  <= wp_d;
        fc_q  <= fc_d;
        cap_q <= cap_d;
        uf_q  <= uf_d;
        of_q  <= of_d;
        mf_q  <= mf_d;
        ar_q  <= ar_d;
        rr_q  <= rr_d;
        ch_q  <= ch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= push_data;
  end

endmodule

// ----- hdl/audio_capture_fifo_card.sv -----
// Top level of the audio capture FIFO card: input and result registers around the card logic.
//
// The block presents a 16-byte register window over a mono 8-bit capture FIFO.
// The input channel (in_valid_i / in_stall_o / in_item_i) carries one bus read,
// peek, write, host frame or reset command per item; the output channel
// (out_valid_o / out_stall_i / out_item_o) returns exactly one result per item,
// in order. The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i)
// sets the window's base address and is always ready; write it only while the
// block is idle.
// An accepted item is held in the input register, is processed there and lands in
// the result register when that register is free or its result is taken. One
// item per cycle is sustained while the receiver does not stall: every item touches
// the FIFO RAM once, with a write port and a registered read port that is kept
// aimed at the FIFO head.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that in_stall_o rises until the result moves.
// Reset empties both registers and the FIFO, stops capture, clears the flags,
// sets both rates to 16000 and the base address to 0x1000_0000. FIFO contents
// are not cleared; they are never read before being written.
module audio_capture_fifo_card (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acfc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acfc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  logic                iv_q;
  acfc_pkg::in_item_t  item_q;
  logic                ov_q;
  acfc_pkg::out_item_t res_q;
  acfc_pkg::out_item_t res;
  logic [31:0]         base_q;
  logic                proc;
  logic                in_take;
  acfc_pkg::mem_req_t  mem_req;
  logic [7:0]          mem_rdata;

  assign proc        = iv_q && (!ov_q || !out_stall_i);
  assign in_stall_o  = iv_q && !proc;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_item_o  = res_q;
  assign cfg_ready_o = 1'b1;

  acfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .item_i      (item_q),
    .base_i      (base_q),
    .mem_rdata_i (mem_rdata),
    .mem_req_o   (mem_req),
    .res_o       (res)
  );

  acfc_ram #(
    .DEPTH (acfc_pkg::FIFO_DEPTH),
    .AW    (acfc_pkg::PTR_W),
    .DW    (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q   <= 1'b0;
      ov_q   <= 1'b0;
      base_q <= acfc_pkg::BASE_RESET;
    end else begin
      if (in_take) begin
        iv_q <= 1'b1;
      end else if (proc) begin
        iv_q <= 1'b0;
      end
      if (proc) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_item_i;
    end
    if (proc) begin
      res_q <= res;
    end
  end

endmodule

// ----- hdl/acfc_checker.sv -----
// Port-level checker for the audio capture FIFO card and its bind statement.
module acfc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input acfc_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input acfc_pkg::out_item_t out_item_o
);

  // A stalled input item stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while stalled");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled result item does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  // A failed access never returns data.
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error |-> out_item_o.read_data == 8'd0)
    else $error("error result carries read data");

  // The reported rate is either stopped or a rate that passed the range check.
  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.capture_rate == '0) ||
                    ((32'(out_item_o.capture_rate) >= acfc_pkg::RATE_MIN) &&
                     (32'(out_item_o.capture_rate) <= acfc_pkg::RATE_MAX)))
    else $error("capture rate outside the allowed range");

endmodule

bind audio_capture_fifo_card acfc_checker u_acfc_checker (.*);

// ----- sim/acfc_card_check.sv -----
// Result checker for the audio capture FIFO card: tracks the card state and compares every result.
`timescale 1ns / 1ps

module acfc_card_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  acfc_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  acfc_pkg::out_item_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [31:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import acfc_pkg::*;

  localparam int REPORT_LINES = 40;

  logic [7:0]        fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  rd_ptr, wr_ptr;
  logic [CNT_W-1:0]  fill;
  logic              running, underflow, overflow, missing;
  logic [RATE_W-1:0] active_rate;
  logic [31:0]       requested_rate;
  logic [CHAN_W-1:0] channel;
  logic [31:0]       window_base;
  out_item_t         card_reply_q [$];
  out_item_t         reply_want, reply_pred;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= REPORT_LINES) begin
      $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic flush_fifo();
    rd_ptr = '0;
    wr_ptr = '0;
    fill   = '0;
  endtask

  task automatic try_start(output logic ok);
    if (requested_rate < RATE_MIN || requested_rate > RATE_MAX) begin
      ok = 1'b0;
    end else begin
      ok = 1'b1;
      if (requested_rate != 32'(active_rate)) flush_fifo();
      active_rate = requested_rate[RATE_W-1:0];
      running     = 1'b1;
      missing     = 1'b0;
    end
  endtask

  task automatic bus_write(input logic [OFF_W-1:0] off, input logic [7:0] v,
                           output logic ok);
    logic started;
    int   shift;
    ok = 1'b1;
    case (off)
      OFF_CTRL: begin
        // Clear, then start, then run or stop; a failed start drops the rest.
        if (v[CTRL_CLEAR]) flush_fifo();
        if (v[CTRL_START]) begin
          try_start(started);
          ok = started;
        end
        if (ok) begin
          if (v[CTRL_RUN]) begin
            if (!running) begin
              try_start(started);
              ok = started;
            end
          end else if (running) begin
            running = 1'b0;
            flush_fifo();
          end
        end
      end
      OFF_STATUS: begin
        if (v[STAT_MISSING]) missing = 1'b0;
        if (v[STAT_UNDER]) underflow = 1'b0;
        if (v[STAT_OVER]) overflow = 1'b0;
      end
      OFF_RATE0, OFF_RATE1, OFF_RATE2, OFF_RATE3: begin
        shift = 8 * int'(off - OFF_RATE0);
        requested_rate[shift +: 8] = v;
      end
      OFF_CHAN: begin
        if (v > CHAN_MAX) begin
          ok = 1'b0;
        end else begin
          channel = v[CHAN_W-1:0];
          flush_fifo();
        end
      end
      default: ;
    endcase
  endtask

  task automatic bus_read(input logic [OFF_W-1:0] off, input logic peek,
                          input logic [31:0] now, output logic [7:0] v);
    v = '0;
    case (off)
      OFF_DATA: begin
        if (fill == '0) begin
          if (!peek) underflow = 1'b1;
          v = EMPTY_BYTE;
        end else begin
          v = fifo_mem[rd_ptr];
          if (!peek) begin
            rd_ptr = PTR_W'((int'(rd_ptr) + 1) % FIFO_DEPTH);
            fill   = fill - 1'b1;
          end
        end
      end
      OFF_CTRL: v = {7'b0, running};
      OFF_STATUS: begin
        v[STAT_ON]       = running;
        v[STAT_NONEMPTY] = (fill != '0);
        v[STAT_FULL]     = (fill == CNT_W'(FIFO_DEPTH));
        v[STAT_MISSING]  = missing;
        v[STAT_UNDER]    = underflow;
        v[STAT_OVER]     = overflow;
      end
      OFF_RATE0, OFF_RATE1, OFF_RATE2, OFF_RATE3:
        v = 8'(requested_rate >> (8 * int'(off - OFF_RATE0)));
      OFF_FILL0: v = fill[7:0];
      OFF_FILL1: v = 8'(fill >> 8);
      OFF_CHAN:  v = 8'(channel);
      OFF_TIME0, OFF_TIME1, OFF_TIME2, OFF_TIME3:
        v = 8'(now >> (8 * int'(off - OFF_TIME0)));
      default: ;
    endcase
  endtask

  task automatic frame_in(input logic [15:0] s, input logic [3:0] chans, input logic rate_ok);
    logic present;
    present = ({1'b0, channel} < chans);
    if (running) begin
      if (!rate_ok || chans == '0 || chans > FRAME_CHANS_MAX || !present) begin
        missing = !present;
      end else begin
        missing = 1'b0;
        if (fill == CNT_W'(FIFO_DEPTH)) begin
          overflow = 1'b1;
        end else begin
          // Offset binary: the top byte with its sign bit inverted.
          fifo_mem[wr_ptr] = {~s[15], s[14:8]};
          wr_ptr = PTR_W'((int'(wr_ptr) + 1) % FIFO_DEPTH);
          fill   = fill + 1'b1;
        end
      end
    end
  endtask

  task automatic predict_reply(input in_item_t it, output out_item_t r);
    logic [32:0] rel;
    logic        ok;
    logic [7:0]  rd;
    r  = '0;
    rd = '0;
    case (it.command)
      CMD_READ, CMD_PEEK, CMD_WRITE: begin
        // An address below the base wraps to a huge offset and fails too.
        rel = {1'b0, it.address} - {1'b0, window_base};
        if (rel >= 33'(REG_COUNT)) begin
          r.error = 1'b1;
        end else if (it.command == CMD_WRITE) begin
          bus_write(rel[OFF_W-1:0], it.write_data, ok);
          r.error = !ok;
        end else begin
          bus_read(rel[OFF_W-1:0], it.command == CMD_PEEK, it.now_ms, rd);
        end
      end
      CMD_FRAME: frame_in(it.frame_sample, it.frame_channels, it.frame_rate_ok);
      CMD_RESET: begin
        running   = 1'b0;
        flush_fifo();
        underflow = 1'b0;
        overflow  = 1'b0;
        missing   = 1'b0;
        requested_rate = 32'(active_rate);
      end
      default: ;
    endcase
    r.read_data    = rd;
    r.capture_rate = running ? active_rate : '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_fifo();
      running        = 1'b0;
      underflow      = 1'b0;
      overflow       = 1'b0;
      missing        = 1'b0;
      active_rate    = RATE_RESET;
      requested_rate = 32'(RATE_RESET);
      channel        = '0;
      window_base    = BASE_RESET;
      card_reply_q.delete();
      pending_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (card_reply_q.size() == 0) begin
          report_mismatch("result without a pending item", 32'(out_item_i), 32'd0);
        end else begin
          reply_want = card_reply_q.pop_front();
          if (out_item_i.read_data !== reply_want.read_data)
            report_mismatch("read_data", 32'(out_item_i.read_data), 32'(reply_want.read_data));
          if (out_item_i.error !== reply_want.error)
            report_mismatch("error", 32'(out_item_i.error), 32'(reply_want.error));
          if (out_item_i.capture_rate !== reply_want.capture_rate)
            report_mismatch("capture_rate", 32'(out_item_i.capture_rate),
                            32'(reply_want.capture_rate));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_reply(in_item_i, reply_pred);
        card_reply_q.push_back(reply_pred);
      end
      if (cfg_valid_i && cfg_ready_i) window_base = cfg_data_i;
      pending_o = card_reply_q.size();
    end
  end

endmodule

// ----- sim/tb_audio_capture_fifo_card.sv -----
// Testbench top for the audio capture FIFO card: drives items and the base register, gives the verdict.
`timescale 1ns / 1ps

module tb_audio_capture_fifo_card;
  import acfc_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 850;
  localparam int PHASES        = 6;
  localparam int FILL_FRAMES   = FIFO_DEPTH + 8;

  localparam logic [2:0] CMD_LAST  = 3'd7;
  localparam logic [7:0] CTL_RUN   = 8'(1 << CTRL_RUN);
  localparam logic [7:0] CTL_CLEAR = 8'(1 << CTRL_CLEAR);
  localparam logic [7:0] CTL_START = 8'(1 << CTRL_START);
  localparam logic [7:0] FLAGS_ALL = 8'((1 << STAT_MISSING) | (1 << STAT_UNDER) | (1 << STAT_OVER));

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t    in_item;
  out_item_t   out_item;
  logic [31:0] cfg_data;
  int          fail_count, pending;
  int          cycle_count = 0;
  int          burst_left, sent_count;
  logic [31:0] cur_base;

  audio_capture_fifo_card uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  acfc_card_check card_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: switches among free-running, light, heavy and periodic stalling.
  initial begin : stall_pattern
    int mode, left;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 3) == 0);
        2:       out_stall = ($urandom_range(0, 3) != 0);
        default: out_stall = ((cycle_count % 5) < 2);
      endcase
    end
  end

  // Fields that the command does not use are filled with noise.
  function automatic in_item_t bus_item(input logic [2:0] cmd, input logic [OFF_W-1:0] off,
                                        input logic [7:0] data);
    in_item_t it;
    it.command        = cmd;
    it.address        = cur_base + 32'(off);
    it.write_data     = data;
    it.now_ms         = $urandom;
    it.frame_sample   = 16'($urandom);
    it.frame_channels = 4'($urandom);
    it.frame_rate_ok  = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t frame_item(input logic [15:0] s, input logic [3:0] chans,
                                          input logic rate_ok);
    in_item_t it;
    it = bus_item(CMD_FRAME, 4'($urandom), 8'($urandom));
    it.address        = $urandom;
    it.frame_sample   = s;
    it.frame_channels = chans;
    it.frame_rate_ok  = rate_ok;
    return it;
  endfunction

  // Sender: bursts of random length, separated by random gaps.
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (it.command <= CMD_RESET) sent_count++;
  endtask

  task automatic write_rate(input logic [31:0] rate);
    send(bus_item(CMD_WRITE, OFF_RATE0, rate[7:0]));
    send(bus_item(CMD_WRITE, OFF_RATE1, rate[15:8]));
    send(bus_item(CMD_WRITE, OFF_RATE2, rate[23:16]));
    send(bus_item(CMD_WRITE, OFF_RATE3, rate[31:24]));
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    in_item_t         it;
    int               kind, n, r, p;
    logic [31:0]      rate;
    logic [7:0]       ctl;
    logic [OFF_W-1:0] off;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    cur_base   = BASE_RESET;
    burst_left = 0;
    sent_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed items at the reset base address.
    send(bus_item(CMD_READ, OFF_DATA, 8'($urandom)));
    send(bus_item(CMD_PEEK, OFF_DATA, 8'($urandom)));
    send(bus_item(CMD_WRITE, OFF_CTRL, CTL_RUN));
    send(frame_item(16'h8000, 4'd1, 1'b1));
    send(frame_item(16'h7FFF, 4'd8, 1'b1));
    send(frame_item(16'h1234, 4'd8, 1'b0));
    send(frame_item(16'h1234, 4'd0, 1'b1));
    send(frame_item(16'h1234, 4'd9, 1'b1));
    send(bus_item(CMD_READ, OFF_STATUS, 8'($urandom)));
    send(bus_item(CMD_PEEK, OFF_DATA, 8'($urandom)));
    send(bus_item(CMD_READ, OFF_DATA, 8'($urandom)));
    send(bus_item(CMD_READ, OFF_FILL0, 8'($urandom)));
    send(bus_item(CMD_WRITE, OFF_CHAN, CHAN_MAX));
    send(frame_item(16'h0000, 4'd4, 1'b1));
    send(bus_item(CMD_WRITE, OFF_CHAN, CHAN_MAX + 8'd1));
    it = bus_item(CMD_READ, OFF_DATA, 8'($urandom));
    it.address = cur_base - 32'd1;
    send(it);
    it.address = cur_base + 32'(REG_COUNT);
    send(it);
    write_rate(RATE_MIN - 32'd1);
    send(bus_item(CMD_WRITE, OFF_CTRL, CTL_START));
    write_rate(RATE_MAX);
    send(bus_item(CMD_WRITE, OFF_CTRL, CTL_CLEAR | CTL_START | CTL_RUN));
    send(bus_item(CMD_WRITE, OFF_STATUS, FLAGS_ALL));
    send(bus_item(CMD_RESET, OFF_DATA, 8'($urandom)));
    send(bus_item(CMD_LAST, OFF_DATA, 8'($urandom)));

    for (p = 0; p < PHASES; p++) begin
      // The base register only moves while the card is idle.
      drain();
      case (p)
        0:       cfg_data = 32'h0000_0000;
        1:       cfg_data = 32'hFFFF_FFF0;
        4:       cfg_data = BASE_RESET;
        default: cfg_data = $urandom_range(0, 32'hFFFF_FFF0);
      endcase
      cfg_valid = 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid = 1'b0;
      cur_base  = cfg_data;

      if (p == 3) begin
        // Run the FIFO into full and overflow, then look at it and drain a little.
        write_rate(32'd44100);
        send(bus_item(CMD_WRITE, OFF_CTRL, CTL_CLEAR | CTL_START | CTL_RUN));
        repeat (FILL_FRAMES) send(frame_item(16'($urandom), 4'd8, 1'b1));
        send(bus_item(CMD_READ, OFF_STATUS, 8'($urandom)));
        send(bus_item(CMD_READ, OFF_FILL0, 8'($urandom)));
        send(bus_item(CMD_READ, OFF_FILL1, 8'($urandom)));
        send(bus_item(CMD_PEEK, OFF_DATA, 8'($urandom)));
        repeat (8) send(bus_item(CMD_READ, OFF_DATA, 8'($urandom)));
        send(bus_item(CMD_WRITE, OFF_STATUS, FLAGS_ALL));
        send(bus_item(CMD_READ, OFF_STATUS, 8'($urandom)));
      end

      sent_count = 0;
      while (sent_count < RANDOM_ITEMS / PHASES) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          n = $urandom_range(4, 24);
          repeat (n) begin
            r = $urandom_range(0, 99);
            send(frame_item((r < 4) ? 16'h8000 : (r < 8) ? 16'h7FFF : 16'($urandom),
                            (r < 75) ? 4'd8 : 4'($urandom_range(0, 15)), (r % 10) != 0));
          end
        end else if (kind < 48) begin
          n = $urandom_range(2, 16);
          repeat (n) begin
            r = $urandom_range(0, 99);
            send(bus_item((r < 80) ? CMD_READ : CMD_PEEK, (r % 4 != 0) ? OFF_DATA : OFF_STATUS,
                          8'($urandom)));
          end
        end else if (kind < 62) begin
          case ($urandom_range(0, 7))
            0:       rate = RATE_MIN;
            1:       rate = RATE_MAX;
            2:       rate = 32'(RATE_RESET);
            3:       rate = 32'd48000;
            4:       rate = $urandom_range(RATE_MIN, RATE_MAX);
            5:       rate = RATE_MIN - 32'd1;
            6:       rate = RATE_MAX + 32'd1;
            default: rate = $urandom;
          endcase
          write_rate(rate);
          case ($urandom_range(0, 5))
            0:       ctl = CTL_RUN;
            1:       ctl = CTL_START | CTL_RUN;
            2:       ctl = CTL_START;
            3:       ctl = CTL_CLEAR | CTL_START | CTL_RUN;
            4:       ctl = CTL_CLEAR | CTL_RUN;
            default: ctl = 8'($urandom);
          endcase
          send(bus_item(CMD_WRITE, OFF_CTRL, ctl));
        end else if (kind < 72) begin
          n = $urandom_range(2, 8);
          repeat (n) send(bus_item(($urandom_range(0, 1) == 0) ? CMD_READ : CMD_PEEK,
                                   4'($urandom_range(0, 15)), 8'($urandom)));
        end else if (kind < 80) begin
          off = 4'($urandom_range(0, 15));
          if (off == OFF_CHAN && $urandom_range(0, 3) != 0) begin
            ctl = 8'($urandom_range(0, int'(CHAN_MAX)));
          end else begin
            ctl = 8'($urandom);
          end
          send(bus_item(CMD_WRITE, off, ctl));
        end else if (kind < 86) begin
          case ($urandom_range(0, 3))
            0:       send(bus_item(CMD_WRITE, OFF_CTRL, 8'd0));
            1:       send(bus_item(CMD_WRITE, OFF_CTRL, CTL_CLEAR));
            2:       send(bus_item(CMD_WRITE, OFF_STATUS, 8'($urandom)));
            default: send(bus_item(CMD_WRITE, OFF_STATUS, FLAGS_ALL));
          endcase
        end else if (kind < 90) begin
          if ($urandom_range(0, 3) == 0) begin
            send(bus_item(3'($urandom_range(int'(CMD_RESET) + 1, int'(CMD_LAST))),
                          4'($urandom), 8'($urandom)));
          end else begin
            send(bus_item(CMD_RESET, 4'($urandom), 8'($urandom)));
          end
        end else if (kind < 93) begin
          // Let every outstanding result come back before going on.
          drain();
          send(bus_item(CMD_READ, OFF_STATUS, 8'($urandom)));
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            it = bus_item(3'($urandom), 4'($urandom), 8'($urandom));
            case ($urandom_range(0, 2))
              0:       it.address = $urandom;
              1:       it.address = cur_base - 32'd1;
              default: it.address = cur_base + 32'(REG_COUNT) + 32'($urandom_range(0, 255));
            endcase
            send(it);
          end
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/acfc_pkg.sv
hdl/acfc_ram.sv
hdl/acfc_ctrl.sv
hdl/audio_capture_fifo_card.sv
hdl/acfc_checker.sv
sim/acfc_card_check.sv
sim/tb_audio_capture_fifo_card.sv
